// ----- hdl/gas_pkg.sv -----
// Shared constants, state codes and helper functions for the grid A* path search.
// Used by grid_astar_path_search_top; no dependencies of its own.
package gas_pkg;

    localparam int GRID_DIM   = 64;
    localparam int HEAP_DEPTH = 16384;

    localparam int CW    = $clog2(GRID_DIM);
    localparam int TW    = 2 * CW;
    localparam int TILES = GRID_DIM * GRID_DIM;
    localparam int LW    = TW + 1;
    localparam int FW    = TW + 1;
    localparam int KW    = FW + TW;
    localparam int NW    = LW + 1;
    localparam int HAW   = $clog2(HEAP_DEPTH);
    localparam int HCW   = HAW + 1;
    localparam int GSW   = 7;

    localparam logic [LW-1:0] COST_INF = {LW{1'b1}};

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [4:0] ST_INIT  = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_RDP   = 5'd2;
    localparam logic [4:0] ST_WS    = 5'd3;
    localparam logic [4:0] ST_WG    = 5'd4;
    localparam logic [4:0] ST_WCK   = 5'd5;
    localparam logic [4:0] ST_CLR   = 5'd6;
    localparam logic [4:0] ST_SEED  = 5'd7;
    localparam logic [4:0] ST_POP   = 5'd8;
    localparam logic [4:0] ST_POP1  = 5'd9;
    localparam logic [4:0] ST_POP2  = 5'd10;
    localparam logic [4:0] ST_SD    = 5'd11;
    localparam logic [4:0] ST_SDL   = 5'd12;
    localparam logic [4:0] ST_SDR   = 5'd13;
    localparam logic [4:0] ST_CUR   = 5'd14;
    localparam logic [4:0] ST_CUR1  = 5'd15;
    localparam logic [4:0] ST_NB    = 5'd16;
    localparam logic [4:0] ST_NB1   = 5'd17;
    localparam logic [4:0] ST_PUSH  = 5'd18;
    localparam logic [4:0] ST_SU    = 5'd19;
    localparam logic [4:0] ST_SU1   = 5'd20;
    localparam logic [4:0] ST_WALK  = 5'd21;
    localparam logic [4:0] ST_WALK1 = 5'd22;

    function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [FW-1:0] manhattan(input logic [CW-1:0] r0, input logic [CW-1:0] c0,
                                                input logic [CW-1:0] r1, input logic [CW-1:0] c1);
        manhattan = FW'(absdiff(r0, r1)) + FW'(absdiff(c0, c1));
    endfunction

endpackage

// ----- hdl/gas_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module gas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/grid_astar_path_search_top.sv -----
// Top level of the grid A* path search: control sequencer, binary heap walk and path trace.
// Depends on gas_pkg and gas_ram.
//
// Usage: each input transaction carries an op in s_axis_tuser and the tile fields in
// s_axis_tdata. Every input transaction yields exactly one output transaction, whose
// m_axis_tuser bit is the ok flag and whose tdata holds path length, row and column.
// A wall write is completed in the idle state, so writes may stream one per cycle while
// the receiver does not stall. A path read passes through ST_RDP because of the registered
// path memory. A search runs the start and goal checks, a pass that clears the cost and
// closed table for every tile, then heap work level by level for every push and pop.
// Each neighbor is bounds-checked, and one on the grid is then checked in the wall and
// node tables; a push climbs the heap level by level. The path trace steps through
// ST_WALK and ST_WALK1 for each tile. The heap memory port and the node table port set
// the search time. A new item is taken while the previous result still waits, as long
// as the result register is emptied in the same cycle.
// After reset the wall map is filled with walls in ST_INIT, during which no item
// is accepted; configuration writes are taken at any time. When the receiver stalls,
// the result register holds and input waits until it drains.
module grid_astar_path_search_top
    import gas_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [GSW-1:0] i_cfg_data,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // row, col, wall, goal_row, goal_col, path_index; zero filled.
    input  logic [39:0]    s_axis_tdata,
    // op.
    input  logic [1:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // path_length, out_row, out_col; zero filled.
    output logic [31:0]    m_axis_tdata,
    // ok.
    output logic [0:0]     m_axis_tuser
);

    logic [4:0]     r_state, n_state;
    logic [TW-1:0]  r_cnt, n_cnt;
    logic [GSW-1:0] r_gs;
    logic [CW:0]    r_n, n_n;
    logic [CW-1:0]  r_sr, n_sr, r_sc, n_sc, r_gr, n_gr, r_gc, n_gc;
    logic [LW-1:0]  r_g, n_g;
    logic [TW-1:0]  r_cur, n_cur, r_nb, n_nb, r_wi, n_wi;
    logic [KW-1:0]  r_top, n_top, r_last, n_last, r_key, n_key, r_kl, n_kl;
    logic [HAW-1:0] r_hi, n_hi;
    logic [HCW-1:0] r_hcnt, n_hcnt;
    logic [1:0]     r_dir, n_dir;
    logic [LW-1:0]  r_found, n_found, r_len, n_len;
    logic           r_ovalid, r_ook;
    logic [LW-1:0]  r_olen;
    logic [CW-1:0]  r_orow, r_ocol;

    logic           res_fire, res_ok;
    logic [LW-1:0]  res_len;
    logic [CW-1:0]  res_row, res_col;

    logic           wall_we, wall_wd, wall_q;
    logic [TW-1:0]  wall_wa, wall_ra;
    logic           node_we;
    logic [NW-1:0]  node_wd, node_q;
    logic [TW-1:0]  node_wa, node_ra;
    logic           par_we;
    logic [TW-1:0]  par_wa, par_wd, par_ra, par_q;
    logic           heap_we;
    logic [HAW-1:0] heap_wa, heap_ra;
    logic [KW-1:0]  heap_wd, heap_q;
    logic           path_we;
    logic [TW-1:0]  path_wa, path_wd, path_ra, path_q;

    logic           in_fire;
    logic [1:0]     in_op;
    logic [CW-1:0]  in_row, in_col, in_gr, in_gc;
    logic           in_wall;
    logic [TW-1:0]  in_idx;
    logic [CW:0]    gs_n;

    logic [TW-1:0]  start_t, goal_t;
    logic [CW:0]    nr_x, nc_x;
    logic           nb_ok;
    logic [TW-1:0]  nb_t;
    logic [LW-1:0]  g_next;
    logic [FW-1:0]  h_nb;
    logic [HCW-1:0] l_idx;
    logic [HCW:0]   l1_idx;
    logic [HAW-1:0] par_idx;
    logic [KW-1:0]  ks;
    logic [HAW-1:0] s_idx;
    logic [LW-1:0]  len1;

    assign in_op   = s_axis_tuser;
    assign in_row  = s_axis_tdata[5:0];
    assign in_col  = s_axis_tdata[11:6];
    assign in_wall = s_axis_tdata[12];
    assign in_gr   = s_axis_tdata[18:13];
    assign in_gc   = s_axis_tdata[24:19];
    assign in_idx  = s_axis_tdata[36:25];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign gs_n          = (r_gs > GSW'(GRID_DIM)) ? (CW+1)'(GRID_DIM) : (CW+1)'(r_gs);

    assign start_t = {r_sr, r_sc};
    assign goal_t  = {r_gr, r_gc};
    assign g_next  = r_g + LW'(1);
    assign h_nb    = manhattan(r_gr, r_gc, r_nb[TW-1:CW], r_nb[CW-1:0]);
    assign l_idx   = {r_hi, 1'b1};
    assign l1_idx  = {1'b0, l_idx} + (HCW+1)'(1);
    assign par_idx = (r_hi - HAW'(1)) >> 1;
    assign len1    = r_len + LW'(1);

    always_comb begin
        nr_x  = {1'b0, r_cur[TW-1:CW]};
        nc_x  = {1'b0, r_cur[CW-1:0]};
        nb_ok = 1'b0;
        case (r_dir)
            DIR_DOWN: begin
                nr_x  = {1'b0, r_cur[TW-1:CW]} + (CW+1)'(1);
                nb_ok = nr_x < r_n;
            end
            DIR_UP: begin
                nr_x  = {1'b0, r_cur[TW-1:CW]} - (CW+1)'(1);
                nb_ok = r_cur[TW-1:CW] != '0;
            end
            DIR_RIGHT: begin
                nc_x  = {1'b0, r_cur[CW-1:0]} + (CW+1)'(1);
                nb_ok = nc_x < r_n;
            end
            DIR_LEFT: begin
                nc_x  = {1'b0, r_cur[CW-1:0]} - (CW+1)'(1);
                nb_ok = r_cur[CW-1:0] != '0;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
        nb_t = {nr_x[CW-1:0], nc_x[CW-1:0]};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_sr    = r_sr;
        n_sc    = r_sc;
        n_gr    = r_gr;
        n_gc    = r_gc;
        n_g     = r_g;
        n_cur   = r_cur;
        n_nb    = r_nb;
        n_wi    = r_wi;
        n_top   = r_top;
        n_last  = r_last;
        n_key   = r_key;
        n_kl    = r_kl;
        n_hi    = r_hi;
        n_hcnt  = r_hcnt;
        n_dir   = r_dir;
        n_found = r_found;
        n_len   = r_len;

        res_fire = 1'b0;
        res_ok   = 1'b0;
        res_len  = r_found;
        res_row  = '0;
        res_col  = '0;

        wall_we = 1'b0;
        wall_wa = r_cnt;
        wall_wd = 1'b1;
        wall_ra = start_t;
        node_we = 1'b0;
        node_wa = r_cnt;
        node_wd = {1'b0, COST_INF};
        node_ra = r_cur;
        par_we  = 1'b0;
        par_wa  = r_nb;
        par_wd  = r_cur;
        par_ra  = r_wi;
        heap_we = 1'b0;
        heap_wa = r_hi;
        heap_wd = r_key;
        heap_ra = '0;
        path_we = 1'b0;
        path_wa = r_len[TW-1:0];
        path_wd = r_wi;
        path_ra = '0;
        ks      = r_kl;
        s_idx   = l_idx[HAW-1:0];

        case (r_state)
            ST_INIT: begin
                wall_we = 1'b1;
                if (r_cnt == TW'(TILES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + TW'(1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    res_fire = 1'b1;
                    case (in_op)
                        OP_WRITE: begin
                            wall_we = 1'b1;
                            wall_wa = {in_row, in_col};
                            wall_wd = in_wall;
                            res_ok  = 1'b1;
                        end
                        OP_SEARCH: begin
                            n_found = '0;
                            res_len = '0;
                            n_n     = gs_n;
                            n_sr    = in_row;
                            n_sc    = in_col;
                            n_gr    = in_gr;
                            n_gc    = in_gc;
                            if ({1'b0, in_row} < gs_n && {1'b0, in_col} < gs_n &&
                                {1'b0, in_gr} < gs_n && {1'b0, in_gc} < gs_n) begin
                                res_fire = 1'b0;
                                n_state  = ST_WS;
                            end
                        end
                        OP_READ: begin
                            if ({1'b0, in_idx} < r_found) begin
                                res_fire = 1'b0;
                                path_ra  = r_found[TW-1:0] - TW'(1) - in_idx;
                                n_state  = ST_RDP;
                            end
                        end
                        default: begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_RDP: begin
                res_fire = 1'b1;
                res_ok   = 1'b1;
                res_row  = path_q[TW-1:CW];
                res_col  = path_q[CW-1:0];
                n_state  = ST_IDLE;
            end
            ST_WS: begin
                wall_ra = start_t;
                n_state = ST_WG;
            end
            ST_WG: begin
                wall_ra = goal_t;
                if (wall_q) begin
                    res_fire = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_WCK;
                end
            end
            ST_WCK: begin
                n_cnt = '0;
                if (wall_q) begin
                    res_fire = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_CLR;
                end
            end
            ST_CLR: begin
                node_we = 1'b1;
                if (r_cnt == TW'(TILES - 1)) begin
                    n_state = ST_SEED;
                end else begin
                    n_cnt = r_cnt + TW'(1);
                end
            end
            ST_SEED: begin
                node_we = 1'b1;
                node_wa = start_t;
                node_wd = '0;
                heap_we = 1'b1;
                heap_wa = '0;
                heap_wd = {manhattan(r_gr, r_gc, r_sr, r_sc), start_t};
                n_hcnt  = HCW'(1);
                n_state = ST_POP;
            end
            ST_POP: begin
                heap_ra = '0;
                if (r_hcnt == '0) begin
                    res_fire = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_POP1;
                end
            end
            ST_POP1: begin
                n_top   = heap_q;
                heap_ra = HAW'(r_hcnt - HCW'(1));
                n_hcnt  = r_hcnt - HCW'(1);
                n_state = ST_POP2;
            end
            ST_POP2: begin
                n_last  = heap_q;
                n_hi    = '0;
                n_state = ST_SD;
            end
            ST_SD: begin
                heap_ra = l_idx[HAW-1:0];
                if (l_idx >= r_hcnt) begin
                    heap_we = r_hcnt != '0;
                    heap_wd = r_last;
                    n_state = ST_CUR;
                end else begin
                    n_state = ST_SDL;
                end
            end
            ST_SDL, ST_SDR: begin
                if (r_state == ST_SDL) begin
                    n_kl = heap_q;
                    ks   = heap_q;
                end else if (heap_q < r_kl) begin
                    ks    = heap_q;
                    s_idx = l1_idx[HAW-1:0];
                end
                heap_ra = l1_idx[HAW-1:0];
                if (r_state == ST_SDL && l1_idx < {1'b0, r_hcnt}) begin
                    n_state = ST_SDR;
                end else if (ks >= r_last) begin
                    heap_we = 1'b1;
                    heap_wd = r_last;
                    n_state = ST_CUR;
                end else begin
                    heap_we = 1'b1;
                    heap_wd = ks;
                    n_hi    = s_idx;
                    n_state = ST_SD;
                end
            end
            ST_CUR: begin
                n_cur   = r_top[TW-1:0];
                node_ra = r_top[TW-1:0];
                n_state = ST_CUR1;
            end
            ST_CUR1: begin
                if (node_q[LW]) begin
                    n_state = ST_POP;
                end else begin
                    node_we = 1'b1;
                    node_wa = r_cur;
                    node_wd = {1'b1, node_q[LW-1:0]};
                    n_g     = node_q[LW-1:0];
                    if (r_cur == goal_t) begin
                        n_wi    = r_cur;
                        n_len   = '0;
                        n_state = ST_WALK;
                    end else begin
                        n_dir   = DIR_DOWN;
                        n_state = ST_NB;
                    end
                end
            end
            ST_NB: begin
                wall_ra = nb_t;
                node_ra = nb_t;
                n_nb    = nb_t;
                if (nb_ok) begin
                    n_state = ST_NB1;
                end else if (r_dir == DIR_LEFT) begin
                    n_state = ST_POP;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            ST_NB1: begin
                if (!wall_q && !node_q[LW] && g_next < node_q[LW-1:0]) begin
                    node_we = 1'b1;
                    node_wa = r_nb;
                    node_wd = {1'b0, g_next};
                    par_we  = 1'b1;
                    n_key   = {FW'(g_next) + h_nb, r_nb};
                    n_state = ST_PUSH;
                end else if (r_dir == DIR_LEFT) begin
                    n_state = ST_POP;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = ST_NB;
                end
            end
            ST_PUSH: begin
                if (r_hcnt >= HCW'(HEAP_DEPTH)) begin
                    if (r_dir == DIR_LEFT) begin
                        n_state = ST_POP;
                    end else begin
                        n_dir   = r_dir + 2'd1;
                        n_state = ST_NB;
                    end
                end else begin
                    n_hi    = r_hcnt[HAW-1:0];
                    n_hcnt  = r_hcnt + HCW'(1);
                    n_state = ST_SU;
                end
            end
            ST_SU, ST_SU1: begin
                heap_ra = par_idx;
                if (r_state == ST_SU && r_hi != '0) begin
                    n_state = ST_SU1;
                end else if (r_state == ST_SU1 && heap_q > r_key) begin
                    heap_we = 1'b1;
                    heap_wd = heap_q;
                    n_hi    = par_idx;
                    n_state = ST_SU;
                end else begin
                    heap_we = 1'b1;
                    heap_wd = r_key;
                    if (r_dir == DIR_LEFT) begin
                        n_state = ST_POP;
                    end else begin
                        n_dir   = r_dir + 2'd1;
                        n_state = ST_NB;
                    end
                end
            end
            ST_WALK: begin
                path_we = 1'b1;
                if (r_wi == start_t || len1 == LW'(TILES)) begin
                    n_found  = len1;
                    res_fire = 1'b1;
                    res_ok   = 1'b1;
                    res_len  = len1;
                    n_state  = ST_IDLE;
                end else begin
                    n_len   = len1;
                    n_state = ST_WALK1;
                end
            end
            ST_WALK1: begin
                n_wi    = par_q;
                n_state = ST_WALK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_cnt    <= '0;
            r_gs     <= GSW'(GRID_DIM);
            r_hcnt   <= '0;
            r_found  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_hcnt  <= n_hcnt;
            r_found <= n_found;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gs <= i_cfg_data;
            end
            if (res_fire) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_sr   <= n_sr;
        r_sc   <= n_sc;
        r_gr   <= n_gr;
        r_gc   <= n_gc;
        r_g    <= n_g;
        r_cur  <= n_cur;
        r_nb   <= n_nb;
        r_wi   <= n_wi;
        r_top  <= n_top;
        r_last <= n_last;
        r_key  <= n_key;
        r_kl   <= n_kl;
        r_hi   <= n_hi;
        r_dir  <= n_dir;
        r_len  <= n_len;
        if (res_fire) begin
            r_ook  <= res_ok;
            r_olen <= res_len;
            r_orow <= res_row;
            r_ocol <= res_col;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ook;
    assign m_axis_tdata  = {7'd0, r_ocol, r_orow, r_olen};

    gas_ram #(.WIDTH(1), .DEPTH(TILES)) u_wall (
        .i_clk(i_clk), .i_we(wall_we), .i_waddr(wall_wa), .i_wdata(wall_wd),
        .i_raddr(wall_ra), .o_rdata(wall_q)
    );

    gas_ram #(.WIDTH(NW), .DEPTH(TILES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_wa), .i_wdata(node_wd),
        .i_raddr(node_ra), .o_rdata(node_q)
    );

    gas_ram #(.WIDTH(TW), .DEPTH(TILES)) u_parent (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(par_ra), .o_rdata(par_q)
    );

    gas_ram #(.WIDTH(KW), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_wa), .i_wdata(heap_wd),
        .i_raddr(heap_ra), .o_rdata(heap_q)
    );

    gas_ram #(.WIDTH(TW), .DEPTH(TILES)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_wa), .i_wdata(path_wd),
        .i_raddr(path_ra), .o_rdata(path_q)
    );

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE))
        else $error("Input taken outside the idle state.");

    a_heap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HCW'(HEAP_DEPTH))
        else $error("Heap count beyond heap depth.");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= LW'(TILES))
        else $error("Path length beyond tile count.");

    a_search_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && in_op == OP_SEARCH) |=> (r_found == '0))
        else $error("Search transaction did not clear the stored path length.");

endmodule
